[rtl/dtt_pkg.sv]
package dtt_pkg;
    localparam int unsigned SLOTS_DEF    = 16;
    localparam longint unsigned ROLL_DEF = 64'd3600000;
    localparam logic [2:0] M_ADD     = 3'd0;
    localparam logic [2:0] M_CANCEL  = 3'd1;
    localparam logic [2:0] M_REFRESH = 3'd2;
    localparam logic [2:0] M_RESET   = 3'd3;
    localparam logic [2:0] M_EXPIRE  = 3'd4;
    localparam logic [2:0] M_WAIT    = 3'd5;
    localparam logic [2:0] M_PEND    = 3'd6;
endpackage

[rtl/deadline_timer_table_top.sv]
// Timer table of SLOTS slots. One item is taken at a time, and o_ready stays low from the
// accepting edge until the last result of that item has been taken. Add, an armed refresh,
// a reset that changes the slot, and next wait give their result after a scan of all
// slots. Cancel, pending, an unused mode and any operation that fails or changes nothing
// give it without a scan. Expire with n due slots runs n+1 scans. The first result comes
// after the second scan, each further result one scan later, and the last one after the
// final scan. The scans use one shared 64-bit compare unit that visits one slot per cycle
// while looking for the earliest or due slot. A result that the receiver does not take
// holds the expire sequence before the next one.
module deadline_timer_table_top
    import dtt_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEF,
    parameter longint unsigned ROLLOVER_MS = ROLL_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_mode,
    input  logic [3:0]  i_slot_id,
    input  logic [63:0] i_interval_ms,
    input  logic        i_repeat_flag,
    input  logic        i_restart_now,
    input  logic [63:0] i_now_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_ok,
    output logic [3:0]  o_fired_slot,
    output logic        o_fired_valid,
    output logic [63:0] o_wait_ms,
    output logic        o_front_notify,
    output logic        o_any_pending,
    output logic        o_last
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_DO = 3'd2,
                           S_OUT = 3'd3, S_FIN = 3'd4;

    logic [63:0] r_dl [SLOTS];
    logic [63:0] r_per [SLOTS];
    logic [SLOTS-1:0] r_rec, r_arm, r_done;
    logic r_np;
    logic [63:0] r_prev;
    logic [2:0] r_st;
    logic [2:0] r_mode;
    logic [3:0] r_sid;
    logic [63:0] r_ival, r_now;
    logic r_rep, r_rn, r_roll;
    logic [SW-1:0] r_cnt;
    logic r_bv;
    logic [SW-1:0] r_best;
    logic r_have;
    logic [SW-1:0] r_slot;
    logic r_keep;

    logic [SLOTS-1:0] n_rec, n_arm, n_done;
    logic n_np;
    logic [63:0] n_prev;
    logic [2:0] n_st;
    logic [SW-1:0] n_cnt, n_best, n_slot, n_dl_idx;
    logic n_bv, n_have, n_keep;
    logic n_valid, n_ok, n_fired_valid, n_front_notify, n_last;
    logic [3:0] n_fired_slot;
    logic [63:0] n_wait_ms, n_dl_val;
    logic n_dl_we, n_per_we;

    // One slot per cycle through the shared compare.
    logic w_cand, w_lt, w_due;
    assign w_lt = (r_dl[r_cnt] < r_dl[r_best]) ||
                  (r_dl[r_cnt] == r_dl[r_best] && r_cnt < r_best);
    assign w_due = r_arm[r_cnt] && (r_roll || r_dl[r_cnt] <= r_now);
    always_comb begin
        if (r_mode == M_EXPIRE)
            w_cand = w_due && !r_done[r_cnt];
        else
            w_cand = r_arm[r_cnt];
    end

    logic w_inr;
    assign w_inr = {28'd0, r_sid} < 32'(SLOTS);
    logic [SW-1:0] w_s;
    assign w_s = SW'(r_sid);
    logic [63:0] w_start;
    assign w_start = r_rn ? r_now : r_dl[w_s] - r_per[w_s];

    logic w_take, w_free;
    assign o_ready = (r_st == S_IDLE) && !o_valid;
    assign w_take = i_valid && o_ready;
    assign w_free = !o_valid || i_ready;

    // Sequencer and next values of the table.
    always_comb begin
        n_st = r_st; n_rec = r_rec; n_arm = r_arm; n_done = r_done; n_np = r_np;
        n_prev = r_prev; n_cnt = r_cnt; n_bv = r_bv; n_best = r_best;
        n_have = r_have; n_slot = r_slot; n_keep = r_keep;
        n_valid = o_valid && !i_ready; n_ok = o_ok; n_fired_slot = o_fired_slot;
        n_fired_valid = o_fired_valid; n_wait_ms = o_wait_ms;
        n_front_notify = o_front_notify; n_last = o_last;
        n_dl_we = 1'b0; n_dl_idx = w_s; n_dl_val = r_now + r_ival; n_per_we = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (w_take) begin
                    n_st = S_DO; n_done = '0; n_have = 1'b0; n_keep = 1'b0;
                end
            end
            S_DO: begin
                // Slot update, then the scan, or straight to the finish.
                n_cnt = '0; n_bv = 1'b0; n_best = '0; n_st = S_SCAN;
                n_ok = 1'b0; n_fired_slot = '0; n_fired_valid = 1'b0;
                n_wait_ms = '0; n_front_notify = 1'b0; n_last = 1'b1;
                if (r_mode <= M_RESET && !w_inr) begin
                    n_st = S_FIN;
                end else begin
                    case (r_mode)
                        M_ADD: begin
                            n_per_we = 1'b1; n_rec[w_s] = r_rep; n_dl_we = 1'b1;
                            n_arm[w_s] = 1'b1; n_ok = 1'b1;
                        end
                        M_CANCEL: begin
                            n_ok = r_arm[w_s]; n_arm[w_s] = 1'b0; n_st = S_FIN;
                        end
                        M_REFRESH: begin
                            if (r_arm[w_s]) begin
                                n_dl_we = 1'b1; n_dl_val = r_now + r_per[w_s]; n_ok = 1'b1;
                            end else n_st = S_FIN;
                        end
                        M_RESET: begin
                            if (r_per[w_s] == r_ival && !r_rn) begin
                                n_ok = 1'b1; n_st = S_FIN;
                            end else if (r_arm[w_s]) begin
                                n_per_we = 1'b1; n_ok = 1'b1;
                                n_dl_we = 1'b1; n_dl_val = w_start + r_ival;
                            end else n_st = S_FIN;
                        end
                        M_EXPIRE: begin
                            if (r_arm == '0) n_st = S_FIN;
                            else n_prev = r_now;
                        end
                        M_WAIT: begin
                            n_np = 1'b0; n_ok = 1'b1;
                        end
                        M_PEND: begin
                            n_ok = 1'b1; n_st = S_FIN;
                        end
                        default: n_st = S_FIN;
                    endcase
                end
            end
            S_SCAN: begin
                if (w_cand && (!r_bv || w_lt)) begin
                    n_bv = 1'b1; n_best = r_cnt;
                end
                // The first expire scan sees every slot before any update, so it
                // also works out whether a slot stays armed afterwards.
                if (r_mode == M_EXPIRE && !r_have && r_arm[r_cnt] &&
                    !(w_due && !r_rec[r_cnt])) n_keep = 1'b1;
                if (r_cnt == SW'(SLOTS - 1)) n_st = S_OUT;
                else n_cnt = r_cnt + 1'b1;
            end
            S_OUT: begin
                case (r_mode)
                    M_WAIT: begin
                        n_st = S_FIN;
                        if (!r_bv) n_wait_ms = '1;
                        else if (r_now >= r_dl[r_best]) n_wait_ms = '0;
                        else n_wait_ms = r_dl[r_best] - r_now;
                    end
                    M_EXPIRE: begin
                        // Wait here while an earlier fired slot is still not taken.
                        if (w_free) begin
                            if (r_bv) begin
                                if (r_have) begin
                                    n_valid = 1'b1; n_ok = 1'b1; n_fired_valid = 1'b1;
                                    n_fired_slot = 4'(r_slot); n_last = 1'b0;
                                end
                                // Re-arm or disarm the found slot at once; it is
                                // out of the later scans through its done bit.
                                n_have = 1'b1; n_slot = r_best; n_done[r_best] = 1'b1;
                                if (r_rec[r_best]) begin
                                    n_dl_we = 1'b1; n_dl_idx = r_best;
                                    n_dl_val = r_now + r_per[r_best];
                                end else n_arm[r_best] = 1'b0;
                                n_cnt = '0; n_bv = 1'b0; n_best = '0; n_st = S_SCAN;
                            end else begin
                                // No more due slots: the final item carries the last one.
                                if (r_have) begin
                                    n_ok = 1'b1; n_fired_valid = 1'b1;
                                    n_fired_slot = 4'(r_slot); n_last = 1'b1;
                                end
                                n_st = S_FIN;
                            end
                        end
                    end
                    default: begin
                        n_st = S_FIN;
                        if (r_bv && r_best == w_s && !r_np) begin
                            n_np = 1'b1; n_front_notify = 1'b1;
                        end
                    end
                endcase
            end
            S_FIN: begin
                if (w_free) begin
                    n_valid = 1'b1; n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; o_valid <= 1'b0; r_arm <= '0; r_rec <= '0;
            r_np <= 1'b0; r_prev <= '0; r_mode <= M_PEND; r_keep <= 1'b0;
            r_done <= '0; r_have <= 1'b0; r_slot <= '0;
            r_cnt <= '0; r_bv <= 1'b0; r_best <= '0;
            o_ok <= 1'b0; o_fired_slot <= '0; o_fired_valid <= 1'b0;
            o_wait_ms <= '0; o_front_notify <= 1'b0; o_last <= 1'b0;
            for (int k = 0; k < SLOTS; k++) begin
                r_dl[k] <= '0; r_per[k] <= '0;
            end
        end else begin
            r_st <= n_st; r_arm <= n_arm; r_rec <= n_rec; r_done <= n_done;
            r_np <= n_np; r_prev <= n_prev; r_cnt <= n_cnt; r_bv <= n_bv;
            r_best <= n_best; r_have <= n_have; r_slot <= n_slot; r_keep <= n_keep;
            o_valid <= n_valid; o_ok <= n_ok; o_fired_slot <= n_fired_slot;
            o_fired_valid <= n_fired_valid; o_wait_ms <= n_wait_ms;
            o_front_notify <= n_front_notify; o_last <= n_last;
            if (w_take) begin
                r_mode <= i_mode; r_sid <= i_slot_id; r_ival <= i_interval_ms;
                r_rep <= i_repeat_flag; r_rn <= i_restart_now; r_now <= i_now_ms;
                r_roll <= (i_now_ms < r_prev) && (r_prev - i_now_ms > ROLLOVER_MS);
            end
            if (n_dl_we) r_dl[n_dl_idx] <= n_dl_val;
            if (n_per_we) r_per[w_s] <= r_ival;
        end
    end

    // Expire reports the table as it stands after all of its updates.
    assign o_any_pending = (r_mode == M_EXPIRE) ? r_keep : (r_arm != '0);
endmodule

[rtl/dtt_checker.sv]
module dtt_checker (
    input logic i_clk, input logic i_rst_n, input logic o_ready, input logic o_valid,
    input logic i_ready, input logic o_fired_valid, input logic o_ok, input logic o_last,
    input logic [63:0] o_wait_ms
);
    // A fired result always reports success.
    a_fired_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_fired_valid |-> o_ok) else $error("fired without ok");
    // A fired result carries no wait time.
    a_fired_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_fired_valid |-> o_wait_ms == '0) else $error("fired with wait");
    // No new item is taken while a result waits.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready with pending result");
    // A stalled result holds its last mark.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_last)) else $error("result changed");
endmodule

bind deadline_timer_table_top dtt_checker u_chk (.*);

[tb/deadline_timer_table_top_tb.sv]
`timescale 1ns / 100ps

module deadline_timer_table_top_tb;
    import dtt_pkg::*;

    localparam int NSLOT = 16;
    localparam longint unsigned ROLL_MS = 64'd3600000;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [2:0] M_SPARE = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_mode = M_PEND;
    logic [3:0]  i_slot_id = '0;
    logic [63:0] i_interval_ms = '0;
    logic        i_repeat_flag = 1'b0;
    logic        i_restart_now = 1'b0;
    logic [63:0] i_now_ms = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_ok;
    logic [3:0]  o_fired_slot;
    logic        o_fired_valid;
    logic [63:0] o_wait_ms;
    logic        o_front_notify;
    logic        o_any_pending;
    logic        o_last;

    typedef struct packed {
        logic        ok;
        logic [3:0]  fired_slot;
        logic        fired_valid;
        logic [63:0] wait_ms;
        logic        front_notify;
        logic        any_pending;
        logic        last;
    } t_timer_result;

    // Predictor copy of the timer table.
    logic [63:0] tbl_deadline [NSLOT];
    logic [63:0] tbl_period [NSLOT];
    logic        tbl_recurring [NSLOT];
    logic        tbl_armed [NSLOT];
    logic        tbl_notify;
    logic [63:0] tbl_prev_time;

    t_timer_result result_queue[$];
    int     error_count = 0;
    int     idle_cycles = 0;
    logic [63:0] clock_now = 64'd1000;

    deadline_timer_table_top DUT (.*);

    always #6 i_clk = ~i_clk;

    function automatic logic slot_first(int a, int b);
        if (tbl_deadline[a] != tbl_deadline[b]) return tbl_deadline[a] < tbl_deadline[b];
        return a < b;
    endfunction

    function automatic int earliest_slot();
        int best;
        best = -1;
        for (int i = 0; i < NSLOT; i++)
            if (tbl_armed[i] && (best < 0 || slot_first(i, best))) best = i;
        return best;
    endfunction

    function automatic logic any_armed();
        for (int i = 0; i < NSLOT; i++) if (tbl_armed[i]) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic front_check(int s);
        if (earliest_slot() == s && !tbl_notify) begin
            tbl_notify = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Work out the results of one item and queue them.
    task automatic predict_timer(input logic [2:0] mode, input logic [3:0] s,
                                 input logic [63:0] ival, input logic rep,
                                 input logic restart, input logic [63:0] now);
        t_timer_result r;
        logic ok, fn, roll;
        logic [63:0] wt, start;
        logic due [NSLOT];
        int order [$];
        int best, e;
        ok = 1'b0;
        fn = 1'b0;
        wt = '0;
        case (mode)
            M_ADD: begin
                tbl_period[s] = ival;
                tbl_recurring[s] = rep;
                tbl_deadline[s] = now + ival;
                tbl_armed[s] = 1'b1;
                fn = front_check(s);
                ok = 1'b1;
            end
            M_CANCEL: begin
                ok = tbl_armed[s];
                tbl_armed[s] = 1'b0;
            end
            M_REFRESH: begin
                if (tbl_armed[s]) begin
                    tbl_deadline[s] = now + tbl_period[s];
                    fn = front_check(s);
                    ok = 1'b1;
                end
            end
            M_RESET: begin
                if (tbl_period[s] == ival && !restart) begin
                    ok = 1'b1;
                end else if (tbl_armed[s]) begin
                    start = restart ? now : tbl_deadline[s] - tbl_period[s];
                    tbl_period[s] = ival;
                    tbl_deadline[s] = start + ival;
                    fn = front_check(s);
                    ok = 1'b1;
                end
            end
            M_EXPIRE: begin
                if (any_armed()) begin
                    roll = now < tbl_prev_time && (tbl_prev_time - now) > ROLL_MS;
                    tbl_prev_time = now;
                    for (int i = 0; i < NSLOT; i++)
                        due[i] = tbl_armed[i] && (roll || tbl_deadline[i] <= now);
                    forever begin
                        best = -1;
                        for (int i = 0; i < NSLOT; i++)
                            if (due[i] && (best < 0 || slot_first(i, best))) best = i;
                        if (best < 0) break;
                        due[best] = 1'b0;
                        order = {order, best};
                    end
                    foreach (order[k]) begin
                        if (tbl_recurring[order[k]])
                            tbl_deadline[order[k]] = now + tbl_period[order[k]];
                        else
                            tbl_armed[order[k]] = 1'b0;
                    end
                    foreach (order[k]) begin
                        r = '{1'b1, 4'(order[k]), 1'b1, 64'd0, 1'b0, any_armed(),
                              k == order.size() - 1};
                        result_queue = {result_queue, r};
                    end
                    if (order.size() > 0) return;
                end
            end
            M_WAIT: begin
                tbl_notify = 1'b0;
                e = earliest_slot();
                if (e < 0) wt = '1;
                else if (now >= tbl_deadline[e]) wt = '0;
                else wt = tbl_deadline[e] - now;
                ok = 1'b1;
            end
            M_PEND: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        r = '{ok, 4'd0, 1'b0, wt, fn, any_armed(), 1'b1};
        result_queue = {result_queue, r};
    endtask

    // Send one item and update the prediction when it is taken. Valid stays high so
    // that the next item can follow at once; a gap or a drain drops it.
    task automatic send_item(input logic [2:0] mode, input logic [3:0] s,
                             input logic [63:0] ival, input logic rep,
                             input logic restart, input logic [63:0] now);
        i_mode <= mode;
        i_slot_id <= s;
        i_interval_ms <= ival;
        i_repeat_flag <= rep;
        i_restart_now <= restart;
        i_now_ms <= now;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        predict_timer(mode, s, ival, rep, restart, now);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (result_queue.size() != 0) @(negedge i_clk);
        repeat (25) @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Receiver stalls on its own pattern and checks each result item.
    always @(negedge i_clk) begin
        if (i_rst_n) i_ready <= ($urandom_range(0, 9) < 7) || (($time / 3000) % 4 == 0);
    end

    always @(posedge i_clk) begin
        t_timer_result w;
        if (i_rst_n && o_valid && i_ready) begin
            if (result_queue.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                w = result_queue.pop_front();
                if (o_ok !== w.ok) report_mismatch("ok", o_ok, w.ok);
                if (o_fired_slot !== w.fired_slot)
                    report_mismatch("fired_slot", o_fired_slot, w.fired_slot);
                if (o_fired_valid !== w.fired_valid)
                    report_mismatch("fired_valid", o_fired_valid, w.fired_valid);
                if (o_wait_ms !== w.wait_ms) report_mismatch("wait_ms", o_wait_ms, w.wait_ms);
                if (o_front_notify !== w.front_notify)
                    report_mismatch("front_notify", o_front_notify, w.front_notify);
                if (o_any_pending !== w.any_pending)
                    report_mismatch("any_pending", o_any_pending, w.any_pending);
                if (o_last !== w.last) report_mismatch("last", o_last, w.last);
            end
        end
    end

    // Watchdog on cycles with no accepted item on either side.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic rand_gap();
        if ($urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
        end
    endtask

    // Extremes of the fields, every mode and the special cases.
    task automatic test_directed();
        send_item(M_PEND, 0, 0, 0, 0, 0);
        send_item(M_WAIT, 0, 0, 0, 0, 64'd5);
        send_item(M_EXPIRE, 0, 0, 0, 0, 64'd5);
        send_item(M_CANCEL, 4'd15, 0, 0, 0, 0);
        send_item(M_REFRESH, 4'd3, 0, 0, 0, 0);
        send_item(M_RESET, 4'd2, 64'd0, 0, 0, 0);
        send_item(M_RESET, 4'd2, 64'd7, 0, 1, 0);
        send_item(M_ADD, 4'd15, '1, 1, 0, 64'd100);
        send_item(M_ADD, 4'd0, 64'd50, 0, 0, 64'd100);
        send_item(M_ADD, 4'd1, 64'd50, 1, 0, 64'd100);
        send_item(M_WAIT, 0, 0, 0, 0, 64'd120);
        send_item(M_ADD, 4'd2, 64'd10, 0, 0, 64'd100);
        send_item(M_RESET, 4'd1, 64'd50, 0, 0, 64'd130);
        send_item(M_RESET, 4'd1, 64'd20, 0, 1, 64'd130);
        send_item(M_RESET, 4'd0, 64'd30, 0, 0, 64'd130);
        send_item(M_REFRESH, 4'd2, 0, 0, 0, 64'd140);
        send_item(M_EXPIRE, 0, 0, 0, 0, 64'd200);
        send_item(M_WAIT, 0, 0, 0, 0, '1);
        send_item(M_EXPIRE, 0, 0, 0, 0, 64'd100);
        send_item(M_EXPIRE, 0, 0, 0, 0, 64'd10);
        send_item(M_SPARE, 4'd9, '1, 1, 1, '1);
        send_item(M_CANCEL, 4'd15, 0, 0, 0, 0);
        send_item(M_ADD, 4'd15, '1, 0, 1, '1);
        send_item(M_EXPIRE, 0, 0, 0, 0, '1);
        send_item(M_CANCEL, 4'd1, 0, 0, 0, 0);
    endtask

    // Mostly timer traffic on a moving clock, with bursts and gaps.
    task automatic test_random(input int count);
        logic [2:0] mode;
        logic [63:0] ival;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) mode = M_ADD;
            else if (pick < 40) mode = M_CANCEL;
            else if (pick < 50) mode = M_REFRESH;
            else if (pick < 60) mode = M_RESET;
            else if (pick < 80) mode = M_EXPIRE;
            else if (pick < 90) mode = M_WAIT;
            else if (pick < 97) mode = M_PEND;
            else mode = M_SPARE;
            case ($urandom_range(0, 9))
                0: ival = {$urandom, $urandom};
                1: ival = 64'd0;
                default: ival = 64'($urandom_range(1, 400));
            endcase
            case ($urandom_range(0, 19))
                0: clock_now = {$urandom, $urandom};
                1: clock_now = clock_now - 64'd4000000;
                2: clock_now = clock_now - 64'($urandom_range(1, 3000));
                default: clock_now = clock_now + 64'($urandom_range(0, 150));
            endcase
            send_item(mode, 4'($urandom_range(0, 15)), ival, 1'($urandom),
                      1'($urandom), clock_now);
            rand_gap();
            if (n == count / 2) wait_drained();
        end
    endtask

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            tbl_deadline[i] = '0;
            tbl_period[i] = '0;
            tbl_recurring[i] = 1'b0;
            tbl_armed[i] = 1'b0;
        end
        tbl_notify = 1'b0;
        tbl_prev_time = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(290);
        wait_drained();
        if (error_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
